// ----- rtl/core/pap_pkg.sv -----
// Shared types and constants for the preferential attachment picker.
`default_nettype none

package pap_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 16;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int EIDX_W    = $clog2(MAX_EDGES);
    localparam int EDGE_W    = EIDX_W + 1;
    localparam int DEG_W     = 11;
    localparam int TOTAL_W   = 20;
    localparam int SUM_W     = DEG_W + IDX_W;
    localparam int WORD_W    = 32;
    localparam int DIV_CNT_W = $clog2(WORD_W);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 11;

    localparam logic [DEG_W-1:0]   DEG_MAX   = {DEG_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_EDGES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_SEED    = 3'd0,
        ST_OPENED  = 3'd1,
        ST_EDGE    = 3'd2,
        ST_NO_PICK = 3'd3,
        ST_SEQ_ERR = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef struct packed {
        logic              operation;
        logic [WORD_W-1:0] rand_word;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] new_node;
        logic [IDX_W-1:0] target_node;
        logic             node_done;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/preferential_attachment_picker.sv -----
// Preferential attachment picker: degree memory, draw sequencer and result register.
// Add and misordered items: the result is registered in res_reg, then in the output register.
// Draw: serial remainder, then the degree memory scan (one entry per cycle through the
//   single read port), then the bump and, when the node completes, append write-back, then the result.
// One item at a time: the input stalls until the result has moved to the output register.
// Reset clears counters, total and configuration (edges 2, limit 1024); the degree
//   memory is not cleared, only entries already written are read.
`default_nettype none

module preferential_attachment_picker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire pap_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output pap_pkg::out_item_t                 out_data,
    input  wire logic                          cfg_we,
    input  wire logic [pap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pap_pkg::CFG_W-1:0]     cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_SCAN   = 6'b000100,
        S_BUMP   = 6'b001000,
        S_APPEND = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [pap_pkg::EDGE_W-1:0]  edges_reg;
    logic [pap_pkg::CNT_W-1:0]   limit_reg;
    logic [pap_pkg::CNT_W-1:0]   nc_reg, nc_next;
    logic [pap_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [pap_pkg::EDGE_W-1:0]  picks_reg, picks_next;
    logic                        sel_reg, sel_next;
    logic [pap_pkg::IDX_W-1:0]   chosen_reg [pap_pkg::MAX_EDGES];
    logic [pap_pkg::IDX_W-1:0]   chosen_next [pap_pkg::MAX_EDGES];

    logic [pap_pkg::SUM_W-1:0]   ran_reg, ran_next;
    logic [pap_pkg::SUM_W-1:0]   sum_reg, sum_next, sum_new;
    logic [pap_pkg::CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                        chk_valid_reg, chk_valid_next;
    logic [pap_pkg::IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic                        chk_hit_reg, chk_hit_next;
    logic                        hit;
    logic [pap_pkg::IDX_W-1:0]   pick_reg, pick_next;
    logic [pap_pkg::DEG_W-1:0]   pick_deg_reg, pick_deg_next;

    pap_pkg::out_item_t          res_reg, res_next;
    logic                        out_valid_reg, out_valid_next;
    pap_pkg::out_item_t          out_data_reg, out_data_next;

    logic [pap_pkg::EDGE_W-1:0]  eff_edges;
    logic [pap_pkg::CNT_W-1:0]   eff_limit;
    logic [pap_pkg::EDGE_W-1:0]  picks_inc;

    logic                        mod_start, mod_done;
    logic [pap_pkg::TOTAL_W-1:0] mod_rem;

    logic [pap_pkg::DEG_W-1:0]   deg_mem [pap_pkg::MAX_NODES];
    logic                        wr_en, rd_en;
    logic [pap_pkg::IDX_W-1:0]   wr_addr, rd_addr;
    logic [pap_pkg::DEG_W-1:0]   wr_data, rd_data;

    function automatic logic [pap_pkg::TOTAL_W-1:0] sat_add(
        input logic [pap_pkg::TOTAL_W-1:0] a,
        input logic [pap_pkg::EDGE_W:0]    b
    );
        logic [pap_pkg::TOTAL_W:0] s;
        s = {1'b0, a} + (pap_pkg::TOTAL_W + 1)'(b);
        if (s > {1'b0, pap_pkg::TOTAL_MAX})
            return pap_pkg::TOTAL_MAX;
        return s[pap_pkg::TOTAL_W-1:0];
    endfunction

    pap_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (in_data.rand_word),
        .divisor   (total_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        if (edges_reg == '0)
            eff_edges = pap_pkg::EDGE_W'(1);
        else if (edges_reg > pap_pkg::EDGE_W'(pap_pkg::MAX_EDGES))
            eff_edges = pap_pkg::EDGE_W'(pap_pkg::MAX_EDGES);
        else
            eff_edges = edges_reg;
        if (limit_reg > pap_pkg::CNT_W'(pap_pkg::MAX_NODES))
            eff_limit = pap_pkg::CNT_W'(pap_pkg::MAX_NODES);
        else
            eff_limit = limit_reg;
    end

    // chosen-list match for the entry about to be read, registered alongside it
    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < pap_pkg::MAX_EDGES; k++)
        begin
            if ((pap_pkg::EDGE_W'(k) < picks_reg)
                && (chosen_reg[k] == rd_idx_reg[pap_pkg::IDX_W-1:0]))
                hit = 1'b1;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign picks_inc = picks_reg + 1'b1;
    assign rd_addr   = rd_idx_reg[pap_pkg::IDX_W-1:0];
    assign sum_new   = sum_reg + pap_pkg::SUM_W'(rd_data);

    always_comb
    begin
        state_next     = state_reg;
        nc_next        = nc_reg;
        total_next     = total_reg;
        picks_next     = picks_reg;
        sel_next       = sel_reg;
        chosen_next    = chosen_reg;
        ran_next       = ran_reg;
        sum_next       = sum_reg;
        rd_idx_next    = rd_idx_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        chk_hit_next   = chk_hit_reg;
        pick_next      = pick_reg;
        pick_deg_next  = pick_deg_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mod_start      = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next.new_node    = nc_reg[pap_pkg::IDX_W-1:0];
                    res_next.target_node = '0;
                    res_next.node_done   = 1'b0;
                    state_next           = S_RESULT;
                    if (in_data.operation == pap_pkg::OP_ADD)
                    begin
                        if (sel_reg)
                            res_next.status = pap_pkg::ST_SEQ_ERR;
                        else if (nc_reg >= eff_limit)
                            res_next.status = pap_pkg::ST_FULL;
                        else if (nc_reg <= pap_pkg::CNT_W'(eff_edges))
                        begin
                            // seed node of degree one
                            wr_en              = 1'b1;
                            wr_addr            = nc_reg[pap_pkg::IDX_W-1:0];
                            wr_data            = pap_pkg::DEG_W'(1);
                            total_next         = sat_add(total_reg, (pap_pkg::EDGE_W + 1)'(1));
                            nc_next            = nc_reg + 1'b1;
                            res_next.status    = pap_pkg::ST_SEED;
                            res_next.node_done = 1'b1;
                        end
                        else
                        begin
                            sel_next        = 1'b1;
                            picks_next      = '0;
                            res_next.status = pap_pkg::ST_OPENED;
                        end
                    end
                    else if (!sel_reg)
                        res_next.status = pap_pkg::ST_SEQ_ERR;
                    else if (total_reg == '0)
                        res_next.status = pap_pkg::ST_NO_PICK;
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (mod_done)
                begin
                    ran_next    = pap_pkg::SUM_W'(mod_rem) + 1'b1;
                    sum_next    = '0;
                    rd_idx_next = '0;
                    state_next  = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (rd_idx_reg < nc_reg)
                begin
                    rd_en          = 1'b1;
                    rd_idx_next    = rd_idx_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_idx_reg[pap_pkg::IDX_W-1:0];
                    chk_hit_next   = hit;
                end
                if (chk_valid_reg)
                begin
                    sum_next = sum_new;
                    if ((sum_new >= ran_reg) && !chk_hit_reg)
                    begin
                        // one read beyond the pick is in flight; it is dropped
                        pick_next      = chk_idx_reg;
                        pick_deg_next  = rd_data;
                        chk_valid_next = 1'b0;
                        state_next     = S_BUMP;
                    end
                end
                else if (rd_idx_reg >= nc_reg)
                begin
                    res_next.status      = pap_pkg::ST_NO_PICK;
                    res_next.new_node    = nc_reg[pap_pkg::IDX_W-1:0];
                    res_next.target_node = '0;
                    res_next.node_done   = 1'b0;
                    state_next           = S_RESULT;
                end
            end

            S_BUMP:
            begin
                if (pick_deg_reg < pap_pkg::DEG_MAX)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pick_reg;
                    wr_data    = pick_deg_reg + 1'b1;
                    total_next = sat_add(total_reg, (pap_pkg::EDGE_W + 1)'(1));
                end
                if (picks_reg < pap_pkg::EDGE_W'(pap_pkg::MAX_EDGES))
                    chosen_next[picks_reg[pap_pkg::EIDX_W-1:0]] = pick_reg;
                res_next.status      = pap_pkg::ST_EDGE;
                res_next.new_node    = nc_reg[pap_pkg::IDX_W-1:0];
                res_next.target_node = pick_reg;
                res_next.node_done   = 1'b0;
                picks_next           = picks_inc;
                state_next           = S_RESULT;
                if (picks_inc >= eff_edges)
                begin
                    sel_next           = 1'b0;
                    picks_next         = '0;
                    res_next.node_done = 1'b1;
                    if (nc_reg < pap_pkg::CNT_W'(pap_pkg::MAX_NODES))
                        state_next = S_APPEND;
                end
            end

            S_APPEND:
            begin
                wr_en      = 1'b1;
                wr_addr    = nc_reg[pap_pkg::IDX_W-1:0];
                wr_data    = pap_pkg::DEG_W'(eff_edges) + 1'b1;
                total_next = sat_add(total_reg, (pap_pkg::EDGE_W + 1)'(eff_edges) + 1'b1);
                nc_next    = nc_reg + 1'b1;
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            edges_reg     <= pap_pkg::EDGE_W'(2);
            limit_reg     <= pap_pkg::CNT_W'(pap_pkg::MAX_NODES);
            nc_reg        <= '0;
            total_reg     <= '0;
            picks_reg     <= '0;
            sel_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nc_reg        <= nc_next;
            total_reg     <= total_next;
            picks_reg     <= picks_next;
            sel_reg       <= sel_next;
            rd_idx_reg    <= rd_idx_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pap_pkg::REG_EDGES: edges_reg <= cfg_data[pap_pkg::EDGE_W-1:0];
                    pap_pkg::REG_LIMIT: limit_reg <= cfg_data[pap_pkg::CNT_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chosen_reg   <= chosen_next;
        ran_reg      <= ran_next;
        sum_reg      <= sum_next;
        chk_idx_reg  <= chk_idx_next;
        chk_hit_reg  <= chk_hit_next;
        pick_reg     <= pick_next;
        pick_deg_reg <= pick_deg_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // degree memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            deg_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= deg_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !wr_en)
        else $error("degree memory written during scan");

    a_picks_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !sel_reg |-> (picks_reg == '0))
        else $error("picks counted outside a selection");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nc_reg <= pap_pkg::CNT_W'(pap_pkg::MAX_NODES))
        else $error("node count beyond capacity");

    a_mod_start: assert property (@(posedge clk) disable iff (!rst_n)
        mod_start |=> (state_reg == S_DIV))
        else $error("remainder started without entering division");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("input transfer left sequencer idle");

endmodule

`default_nettype wire

// ----- rtl/core/pap_mod.sv -----
// Restoring bit-serial remainder unit: one dividend bit per cycle.
`default_nettype none

module pap_mod (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pap_pkg::WORD_W-1:0]  dividend,
    input  wire logic [pap_pkg::TOTAL_W-1:0] divisor,
    output logic                             done,
    output logic [pap_pkg::TOTAL_W-1:0]      remainder
);

    logic                             run_reg, run_next;
    logic                             done_reg, done_next;
    logic [pap_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [pap_pkg::WORD_W-1:0]       quo_reg, quo_next;
    logic [pap_pkg::TOTAL_W-1:0]      rem_reg, rem_next;
    logic [pap_pkg::TOTAL_W-1:0]      div_reg, div_next;
    logic [pap_pkg::TOTAL_W:0]        trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[pap_pkg::WORD_W-1]};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (run_reg)
        begin
            // remainder stays below the divisor, so the trial fits one extra bit
            if (trial >= {1'b0, div_reg})
                rem_next = pap_pkg::TOTAL_W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[pap_pkg::TOTAL_W-1:0];
            quo_next = {quo_reg[pap_pkg::WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pap_pkg::DIV_CNT_W'(pap_pkg::WORD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- dv/tb_preferential_attachment_picker.sv -----
// Self-checking testbench for the preferential attachment picker, with its own degree-table predictor.
`default_nettype none

module tb_preferential_attachment_picker;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    pap_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    pap_pkg::out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [pap_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pap_pkg::CFG_W-1:0] cfg_data = '0;

    preferential_attachment_picker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state
    bit [pap_pkg::DEG_W-1:0]   deg_mem [pap_pkg::MAX_NODES];
    bit [pap_pkg::TOTAL_W-1:0] deg_sum;
    int unsigned               nodes;
    int unsigned               picks;
    bit [pap_pkg::IDX_W-1:0]   chosen [pap_pkg::MAX_EDGES];
    bit                        open_sel;
    bit [4:0]                  edges_reg = 5'd2;
    bit [pap_pkg::CFG_W-1:0]   limit_reg = 11'd1024;

    pap_pkg::out_item_t awaited_outcomes [$];
    pap_pkg::out_item_t oldest_outcome;
    int unsigned items_sent;
    int unsigned errors;
    int unsigned burst_left;
    int unsigned stall_run;
    int unsigned stall_mode;

    function automatic int unsigned edge_quota();
        if (edges_reg == 0)
            return 1;
        if (edges_reg > pap_pkg::MAX_EDGES)
            return pap_pkg::MAX_EDGES;
        return edges_reg;
    endfunction

    function automatic void add_to_total(input int unsigned v);
        int unsigned t;
        t = deg_sum + v;
        deg_sum = (t > pap_pkg::TOTAL_MAX) ? pap_pkg::TOTAL_MAX : t[pap_pkg::TOTAL_W-1:0];
    endfunction

    function automatic pap_pkg::out_item_t predict_attachment(input pap_pkg::in_item_t it);
        pap_pkg::out_item_t r;
        int unsigned m;
        int unsigned lim;
        int unsigned ran;
        int unsigned acc;
        int unsigned pick;
        int unsigned i;
        int unsigned k;
        bit          hit;
        bit          taken;
        m = edge_quota();
        lim = (limit_reg > pap_pkg::MAX_NODES) ? pap_pkg::MAX_NODES : limit_reg;
        r.status = pap_pkg::ST_SEQ_ERR;
        r.new_node = nodes[pap_pkg::IDX_W-1:0];
        r.target_node = '0;
        r.node_done = 1'b0;
        if (it.operation == pap_pkg::OP_ADD)
        begin
            if (open_sel)
                r.status = pap_pkg::ST_SEQ_ERR;
            else if (nodes >= lim)
                r.status = pap_pkg::ST_FULL;
            else if (nodes <= m)
            begin
                deg_mem[nodes] = pap_pkg::DEG_W'(1);
                add_to_total(1);
                nodes++;
                r.status = pap_pkg::ST_SEED;
                r.node_done = 1'b1;
            end
            else
            begin
                open_sel = 1'b1;
                picks = 0;
                r.status = pap_pkg::ST_OPENED;
            end
        end
        else if (!open_sel)
            r.status = pap_pkg::ST_SEQ_ERR;
        else if (deg_sum == 0)
            r.status = pap_pkg::ST_NO_PICK;
        else
        begin
            ran = it.rand_word % deg_sum + 1;
            acc = 0;
            hit = 1'b0;
            pick = 0;
            for (i = 0; i < nodes && !hit; i++)
            begin
                acc += deg_mem[i];
                if (acc >= ran)
                begin
                    taken = 1'b0;
                    for (k = 0; k < picks && k < pap_pkg::MAX_EDGES; k++)
                        if (chosen[k] == i[pap_pkg::IDX_W-1:0])
                            taken = 1'b1;
                    if (!taken)
                    begin
                        pick = i;
                        hit = 1'b1;
                    end
                end
            end
            if (!hit)
                r.status = pap_pkg::ST_NO_PICK;
            else
            begin
                // a saturated degree still counts as a pick
                if (deg_mem[pick] < pap_pkg::DEG_MAX)
                begin
                    deg_mem[pick]++;
                    add_to_total(1);
                end
                if (picks < pap_pkg::MAX_EDGES)
                    chosen[picks] = pick[pap_pkg::IDX_W-1:0];
                picks++;
                r.status = pap_pkg::ST_EDGE;
                r.target_node = pick[pap_pkg::IDX_W-1:0];
                if (picks >= m)
                begin
                    r.node_done = 1'b1;
                    if (nodes < pap_pkg::MAX_NODES)
                    begin
                        deg_mem[nodes] = pap_pkg::DEG_W'(m + 1);
                        add_to_total(m + 1);
                        nodes++;
                    end
                    open_sel = 1'b0;
                    picks = 0;
                end
            end
        end
        return r;
    endfunction

    // Receiver: stall pattern in runs of quiet, held and choppy stretches
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_run = $urandom_range(1, 16);
            stall_mode = $urandom_range(0, 3);
        end
        stall_run--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'b1;
            default: out_stall <= ($urandom_range(0, 2) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %p", $time, out_data);
                errors++;
            end
            else
            begin
                oldest_outcome = awaited_outcomes.pop_front();
                if (out_data.status !== oldest_outcome.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time,
                             oldest_outcome.status, out_data.status);
                    errors++;
                end
                if (out_data.new_node !== oldest_outcome.new_node)
                begin
                    $display("%0t: new_node expected %0d, got %0d", $time,
                             oldest_outcome.new_node, out_data.new_node);
                    errors++;
                end
                if (out_data.target_node !== oldest_outcome.target_node)
                begin
                    $display("%0t: target_node expected %0d, got %0d", $time,
                             oldest_outcome.target_node, out_data.target_node);
                    errors++;
                end
                if (out_data.node_done !== oldest_outcome.node_done)
                begin
                    $display("%0t: node_done expected %0d, got %0d", $time,
                             oldest_outcome.node_done, out_data.node_done);
                    errors++;
                end
            end
        end
    end

    // Called at a falling edge, returns at a falling edge
    task automatic send_item(input logic op, input logic [pap_pkg::WORD_W-1:0] word);
        pap_pkg::in_item_t  it;
        pap_pkg::out_item_t expected;
        it.operation = op;
        it.rand_word = word;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        expected = predict_attachment(it);
        awaited_outcomes.insert(awaited_outcomes.size(), expected);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_draw();
        logic [pap_pkg::WORD_W-1:0] w;
        case ($urandom_range(0, 15))
            0: w = '0;
            1: w = '1;
            default: w = $urandom;
        endcase
        send_item(pap_pkg::OP_DRAW, w);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (awaited_outcomes.size() != 0);
    endtask

    task automatic write_reg(input logic [pap_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[pap_pkg::CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == pap_pkg::REG_EDGES)
            edges_reg = value[4:0];
        else
            limit_reg = value[pap_pkg::CFG_W-1:0];
    endtask

    // Defaults: each node attaches to 2 targets, so nodes 0..2 are seeds
    task automatic test_seed_and_select();
        send_item(pap_pkg::OP_DRAW, 32'h0);          // draw with no selection open
        send_item(pap_pkg::OP_ADD, 32'h0);
        send_item(pap_pkg::OP_ADD, 32'hFFFF_FFFF);
        send_item(pap_pkg::OP_ADD, 32'h0);
        send_item(pap_pkg::OP_ADD, 32'h0);           // opens a selection
        send_item(pap_pkg::OP_ADD, 32'h0);           // add while selecting
        send_item(pap_pkg::OP_DRAW, 32'd2);          // lands on node 2
        send_item(pap_pkg::OP_DRAW, 32'd2);          // node 2 again, already chosen: no pick
        send_item(pap_pkg::OP_DRAW, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_edges_lowered();
        write_reg(pap_pkg::REG_EDGES, 6);
        repeat (4) send_item(pap_pkg::OP_ADD, $urandom);
        send_draw();
        send_draw();
        wait_idle();
        // zero saturates to one, so the next pick finishes the node
        write_reg(pap_pkg::REG_EDGES, 0);
        send_draw();
        wait_idle();
    endtask

    task automatic test_node_limit();
        write_reg(pap_pkg::REG_LIMIT, 0);
        send_item(pap_pkg::OP_ADD, 32'h0);
        send_draw();
        wait_idle();
        write_reg(pap_pkg::REG_LIMIT, 2047);
        send_item(pap_pkg::OP_ADD, 32'h0);
        send_draw();
        wait_idle();
        write_reg(pap_pkg::REG_LIMIT, 1);
        send_item(pap_pkg::OP_ADD, 32'h0);
        wait_idle();
    endtask

    task automatic test_random();
        int unsigned phase;
        int unsigned e;
        int unsigned l;
        int unsigned phase_end;
        int unsigned n;
        int unsigned pick_kind;
        for (phase = 0; phase < 9; phase++)
        begin
            wait_idle();
            case (phase)
                0: begin e = 1; l = 1024; end
                1: begin e = 2; l = nodes + 6; end
                2: begin e = 3; l = 2047; end
                3: begin e = $urandom_range(1, 16); l = 1024; end
                4: begin e = 16; l = 1024; end
                5: begin e = 31; l = nodes + 3; end
                6: begin e = $urandom_range(0, 31); l = $urandom_range(0, 2047); end
                7: begin e = 1; l = 1024; end
                default: begin e = $urandom_range(0, 31); l = $urandom_range(nodes, 1024); end
            endcase
            write_reg(pap_pkg::REG_EDGES, e);
            write_reg(pap_pkg::REG_LIMIT, l);
            phase_end = items_sent + 55;
            while (items_sent < phase_end)
            begin
                pick_kind = $urandom_range(0, 99);
                if (pick_kind < 80)
                begin
                    // well-formed: add, then draws until the node is complete, at most 3 * quota + 2 of them
                    send_item(pap_pkg::OP_ADD, $urandom);
                    n = 0;
                    while (open_sel && n < 3 * edge_quota() + 2)
                    begin
                        send_draw();
                        n++;
                    end
                end
                else if (pick_kind < 90)
                    send_item(1'($urandom_range(0, 1)), $urandom);
                else
                begin
                    // broken sequence, which may be left open for the next add to trip over
                    send_item(pap_pkg::OP_ADD, $urandom);
                    repeat ($urandom_range(0, edge_quota())) send_draw();
                end
                if ($urandom_range(0, 29) == 0)
                    wait_idle();
            end
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_seed_and_select();
        test_edges_lowered();
        test_node_limit();
        test_random();
        wait_idle();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/pap_pkg.sv
rtl/core/pap_mod.sv
rtl/core/preferential_attachment_picker.sv
dv/tb_preferential_attachment_picker.sv
